FILE: rtl/tsq_pkg.sv
// Shared types and codes for the timer slot sorted deadline queue.
// No dependencies; every other file imports this package.
`default_nettype none

package tsq_pkg;

    localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

    // request codes
    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_SET   = 2'd2;

    // status codes
    localparam logic [1:0] STS_DONE   = 2'd0;
    localparam logic [1:0] STS_FULL   = 2'd1;
    localparam logic [1:0] STS_REJECT = 2'd2;

    localparam int IN_BITS  = 72;
    localparam int OUT_BITS = 48;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INSERT,
        ST_FINISH
    } t_state;

    // commands to the slot mark tracker
    typedef struct packed {
        logic scan_start;
        logic clr;
        logic set;
    } t_mark_cmd;

    typedef struct packed {
        logic done;
        logic found;
    } t_scan_rsp;

    // what a list cell shows its right-hand neighbour
    typedef struct packed {
        logic valid;
        logic after;
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: rtl/tsq_cell.sv
// One cell of the sorted deadline list: holds a slot number and its deadline.
// Depends on tsq_pkg.
`default_nettype none

module tsq_cell
    import tsq_pkg::*;
#(
    parameter int SW = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_ins,
    input  wire logic [SW-1:0] i_new_slot,
    input  wire logic [31:0]   i_new_dl,
    input  wire t_cell_ctl     i_left_ctl,
    input  wire logic [SW-1:0] i_left_slot,
    input  wire logic [31:0]   i_left_dl,
    output t_cell_ctl          o_ctl,
    output logic [SW-1:0]      o_slot,
    output logic [31:0]        o_dl
);

    logic          r_valid;
    logic [SW-1:0] r_slot;
    logic [31:0]   r_dl;
    logic          w_after;

    // empty cells sit past the end of the list, so they count as later
    assign w_after = !r_valid || (r_dl >= i_new_dl);

    assign o_ctl  = t_cell_ctl'{valid: r_valid, after: w_after};
    assign o_slot = r_slot;
    assign o_dl   = r_dl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ins && w_after) begin
            r_valid <= i_left_ctl.after ? i_left_ctl.valid : 1'b1;
        end
    end

    // first later cell takes the new item, the ones behind it shift right
    always_ff @(posedge i_clk) begin
        if (i_ins && w_after) begin
            r_slot <= i_left_ctl.after ? i_left_slot : i_new_slot;
            r_dl   <= i_left_ctl.after ? i_left_dl   : i_new_dl;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tsq_alloc.sv
// Slot marks (taken, listed) and the lowest-free-slot scanner.
// Depends on tsq_pkg.
`default_nettype none

module tsq_alloc
    import tsq_pkg::*;
#(
    parameter int SLOT_COUNT = 64,
    parameter int SW         = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_mark_cmd     i_cmd,
    input  wire logic [SW-1:0] i_slot,
    output logic               o_listed,
    output t_scan_rsp          o_rsp,
    output logic [SW-1:0]      o_grant
);

    localparam logic [SW-1:0] LAST = SW'(SLOT_COUNT - 1);

    logic [SLOT_COUNT-1:0] r_taken;
    logic [SLOT_COUNT-1:0] r_listed;
    logic                  r_busy;
    logic [SW-1:0]         r_scan;
    logic                  w_hit;

    assign o_listed = r_listed[i_slot];
    assign w_hit    = r_busy && !r_taken[r_scan];
    assign o_rsp    = t_scan_rsp'{done: w_hit || (r_busy && (r_scan == LAST)),
                                  found: w_hit};
    assign o_grant  = r_scan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_scan <= SW'(1);
        end else if (i_cmd.scan_start) begin
            r_busy <= 1'b1;
            r_scan <= SW'(1);
        end else if (r_busy) begin
            if (o_rsp.done) begin
                r_busy <= 1'b0;
            end else begin
                r_scan <= r_scan + 1'b1;
            end
        end
    end

    // a slot never leaves the list once set; free only drops the taken mark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken  <= SLOT_COUNT'(1);
            r_listed <= SLOT_COUNT'(1);
        end else begin
            if (w_hit) begin
                r_taken[r_scan] <= 1'b1;
            end
            if (i_cmd.clr) begin
                r_taken[i_slot] <= 1'b0;
            end
            if (i_cmd.set) begin
                r_taken[i_slot]  <= 1'b1;
                r_listed[i_slot] <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/timer_slot_sorted_deadline_queue.sv
// Timer slot table: slot allocator plus a deadline-sorted list of timers.
// Depends on tsq_pkg, tsq_alloc and tsq_cell.
//
// Requests come in on the s_axis channel, one result item per request on
// m_axis. Allocate grants the lowest free slot (slot 0 is the sentinel and
// never granted), free drops a slot's mark but leaves it in the list, set
// links a slot in by deadline = timeout + current time (mod 2^32).
// Every result carries the list head and its deadline after the request.
// After accept, free and rejected requests go straight to the finish step,
// which loads the result register; set first registers the deadline sum at
// accept, then shifts the row of list cells in parallel in the insert step,
// and allocate first runs the scanner that tests one slot mark a cycle.
// A new request is taken the cycle after the result is loaded.
// One request is in flight at a time; s_axis_tready is high whenever the
// engine is idle, even while the previous result waits in the output
// register. If m_axis_tready stays low, the finished request holds in its
// last step until the output register empties.
// Reset (synchronous, active low) empties the list, frees all slots but
// the sentinel and takes effect at once; no clearing pass is needed.
`default_nettype none

module timer_slot_sorted_deadline_queue
    import tsq_pkg::*;
#(
    parameter int SLOT_COUNT = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // req_type[1:0], slot_index[7:2], timeout_ticks[39:8], current_time[71:40]
    input  wire logic [IN_BITS-1:0]  s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // status[1:0], granted_slot[7:2], first_slot[13:8], earliest_deadline[45:14]
    output logic [OUT_BITS-1:0]      m_axis_tdata
);

    localparam int          SW         = $clog2(SLOT_COUNT);
    localparam int          CELLS      = SLOT_COUNT - 1;
    localparam logic [31:0] SLOT_LIMIT = 32'(SLOT_COUNT);

    t_state r_state;
    t_state n_state;

    logic [SW-1:0]       r_slot;
    logic [31:0]         r_dl;
    logic [1:0]          r_status;
    logic [SW-1:0]       r_grant;
    logic                r_out_valid;
    logic [OUT_BITS-1:0] r_out_data;

    logic [1:0]    w_req;
    logic [5:0]    w_idx;
    logic [31:0]   w_tmo;
    logic [31:0]   w_now;
    logic [SW-1:0] w_in_slot;
    logic          w_idx_ok;
    logic          w_accept;
    logic          w_listed;
    logic          w_ins;
    logic          w_load;
    logic [1:0]    w_status;
    t_mark_cmd     w_cmd;
    t_scan_rsp     w_rsp;
    logic [SW-1:0] w_grant;
    logic [SW-1:0] w_head_slot;
    logic [31:0]   w_head_dl;

    t_cell_ctl     w_ctl   [CELLS];
    logic [SW-1:0] w_cslot [CELLS];
    logic [31:0]   w_cdl   [CELLS];

    assign w_req     = s_axis_tdata[1:0];
    assign w_idx     = s_axis_tdata[7:2];
    assign w_tmo     = s_axis_tdata[39:8];
    assign w_now     = s_axis_tdata[71:40];
    assign w_in_slot = SW'(w_idx);
    assign w_idx_ok  = 32'(w_idx) < SLOT_LIMIT;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    tsq_alloc #(
        .SLOT_COUNT (SLOT_COUNT),
        .SW         (SW)
    ) u_alloc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_slot   (w_in_slot),
        .o_listed (w_listed),
        .o_rsp    (w_rsp),
        .o_grant  (w_grant)
    );

    genvar gi;
    generate
        for (gi = 0; gi < CELLS; gi++) begin : g_cell
            if (gi == 0) begin : g_first
                tsq_cell #(
                    .SW (SW)
                ) u_cell (
                    .i_clk       (i_clk),
                    .i_rst_n     (i_rst_n),
                    .i_ins       (w_ins),
                    .i_new_slot  (r_slot),
                    .i_new_dl    (r_dl),
                    .i_left_ctl  (t_cell_ctl'{valid: 1'b1, after: 1'b0}),
                    .i_left_slot (r_slot),
                    .i_left_dl   (r_dl),
                    .o_ctl       (w_ctl[gi]),
                    .o_slot      (w_cslot[gi]),
                    .o_dl        (w_cdl[gi])
                );
            end else begin : g_rest
                tsq_cell #(
                    .SW (SW)
                ) u_cell (
                    .i_clk       (i_clk),
                    .i_rst_n     (i_rst_n),
                    .i_ins       (w_ins),
                    .i_new_slot  (r_slot),
                    .i_new_dl    (r_dl),
                    .i_left_ctl  (w_ctl[gi-1]),
                    .i_left_slot (w_cslot[gi-1]),
                    .i_left_dl   (w_cdl[gi-1]),
                    .o_ctl       (w_ctl[gi]),
                    .o_slot      (w_cslot[gi]),
                    .o_dl        (w_cdl[gi])
                );
            end
        end
    endgenerate

    // an empty row means the sentinel heads the list
    assign w_head_slot = w_ctl[0].valid ? w_cslot[0] : '0;
    assign w_head_dl   = w_ctl[0].valid ? w_cdl[0]   : ALL_ONES;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_req == REQ_ALLOC) begin
                        n_state = ST_SCAN;
                    end else if (w_req == REQ_SET && w_idx_ok && !w_listed) begin
                        n_state = ST_INSERT;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                if (w_rsp.done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_INSERT: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        w_cmd    = '0;
        w_ins    = 1'b0;
        w_load   = 1'b0;
        w_status = STS_REJECT;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_req)
                        REQ_ALLOC: begin
                            w_cmd.scan_start = 1'b1;
                            w_status         = STS_FULL;
                        end
                        REQ_FREE: begin
                            if (w_idx_ok && w_idx != 6'd0) begin
                                w_cmd.clr = 1'b1;
                                w_status  = STS_DONE;
                            end
                        end
                        REQ_SET: begin
                            if (w_idx_ok && !w_listed) begin
                                w_cmd.set = 1'b1;
                                w_status  = STS_DONE;
                            end
                        end
                        default: begin
                            w_status = STS_REJECT;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                w_status = w_rsp.found ? STS_DONE : STS_FULL;
            end
            ST_INSERT: begin
                w_ins = 1'b1;
            end
            ST_FINISH: begin
                w_load = !r_out_valid || m_axis_tready;
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_slot   <= w_in_slot;
            r_dl     <= w_tmo + w_now;
            r_status <= w_status;
            r_grant  <= '0;
        end
        if (r_state == ST_SCAN && w_rsp.done) begin
            r_status <= w_status;
            r_grant  <= w_rsp.found ? w_grant : '0;
        end
        if (w_load) begin
            r_out_data <= {2'b00, w_head_dl, 6'(w_head_slot), 6'(r_grant), r_status};
        end
    end

endmodule

`default_nettype wire
